// ----- hdl/spectrum_tone_notch_detector_macros.svh -----
// Assertion macros for the spectrum tone notch detector checker.
`ifndef SPECTRUM_TONE_NOTCH_DETECTOR_MACROS_SVH
`define SPECTRUM_TONE_NOTCH_DETECTOR_MACROS_SVH

// Check a consequence in the same cycle as its cause, quiet while reset is high.
`define STND_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its cause, quiet while reset is high.
`define STND_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/stnd_pkg.sv -----
`timescale 1ns / 1ps
// Shared field widths, constants and types of the spectrum tone notch detector.
package stnd_pkg;

   localparam int LEVEL_W      = 14;
   localparam int HZ_W         = 14;
   localparam int PEAK_BIN_W   = 8;
   localparam int REQ_TDATA_W  = 16;
   localparam int RSP_TDATA_W  = 24;
   localparam int CSR_DATA_W   = 14;
   localparam int CSR_INDEX_W  = 2;

   localparam int BIN_COUNT_DEF     = 250;
   localparam int HISTORY_DEPTH_DEF = 3;
   localparam int BIN_STEP_HZ_DEF   = 50;

   // 6 dB in 1/64 dB units
   localparam int MARGIN_6DB        = 384;
   localparam int ROUND_HZ          = 50;
   localparam int HZ_MAX            = 8191;
   localparam int PASSBAND_LOW_RST  = 0;
   localparam int PASSBAND_HIGH_RST = 3000;

   localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = {1'b1, {(LEVEL_W-1){1'b0}}};
   localparam logic signed [HZ_W-1:0]    EMPTY_NOTCH_HZ = HZ_W'(3000);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PASSBAND_LOW   = 2'd0,
      CSR_PASSBAND_HIGH  = 2'd1,
      CSR_LOWER_SIDEBAND = 2'd2
   } csr_index_type;

   // Result payload, last member in the lowest bits
   typedef struct packed {
      logic [PEAK_BIN_W-1:0]  peak_bin;
      logic signed [HZ_W-1:0] notch_center_hz;
      logic                   history_agrees;
      logic                   tone_found;
   } rsp_payload_type;

endpackage

// ----- hdl/spectrum_tone_notch_detector.sv -----
`timescale 1ns / 1ps
// Spectrum tone detector that proposes a notch centre once per spectrum frame.
//
// Usage:
//   req_ channel carries one power bin per transaction, in bin order; req_tlast
//   marks the last bin of a frame. rsp_ channel carries one transaction per
//   frame, with the tone decision, history agreement, notch centre and peak bin.
//   csr_ port writes the passband edges and the sideband select; write only
//   while no frame is in flight.
// Throughput: one bin per clock; a frame end waits while the result stages are full.
// Result path: the transaction carrying req_tlast loads the input register, then
//   the frame result passes the accumulator snapshot, multiply stage, rounding
//   stage, frequency stage and history/output register.
// Reset: synchronous, active high; clears the frame accumulators, the tone
//   history, the passband registers (0 Hz .. 3000 Hz, upper sideband) and all
//   valid flags. No clearing pass is needed.
// Stall: each stage holds while the stage after it is full. Bins keep flowing
//   into the accumulator while results wait; only a frame end stalls, and only
//   once every stage downstream of the accumulator is occupied.
module spectrum_tone_notch_detector
   import stnd_pkg::*;
#(
   parameter int BIN_COUNT     = BIN_COUNT_DEF,
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
   parameter int BIN_STEP_HZ   = BIN_STEP_HZ_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [13:0] bin_level, [15:14] zero
   input  logic                   req_tlast,   // frame_end
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [0] tone_found, [1] history_agrees,
                                               // [15:2] notch_center_hz, [23:16] peak_bin
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // ---------------------------------------------------------------------------
   // Derived widths and constants
   // ---------------------------------------------------------------------------
   localparam int IDX_W   = $clog2(BIN_COUNT + 1);
   localparam int SUM_W   = LEVEL_W + IDX_W;
   localparam int CMP_W   = SUM_W + 3;
   localparam int LVX_W   = LEVEL_W + 1;
   localparam int WIN_W   = ((IDX_W > HZ_W) ? IDX_W : HZ_W) + 2;
   localparam int CENTRE  = BIN_COUNT / 2;
   localparam int SLOT_W  = $clog2(HISTORY_DEPTH);

   // Passband edge / step: reciprocal multiply, exact for any 14-bit magnitude
   localparam int DIV_SH  = CSR_DATA_W + $clog2(BIN_STEP_HZ + 1);
   localparam int DIV_M_W = DIV_SH + 1;
   localparam logic [DIV_M_W-1:0] DIV_M =
      DIV_M_W'(((longint'(1) << DIV_SH) + BIN_STEP_HZ - 1) / BIN_STEP_HZ);
   localparam int START_RST = CENTRE + PASSBAND_LOW_RST / BIN_STEP_HZ;
   localparam int STOP_RST  = CENTRE + PASSBAND_HIGH_RST / BIN_STEP_HZ;

   // Tone frequency arithmetic
   localparam int K_W         = IDX_W + 1;
   localparam int STEP_W      = $clog2(BIN_STEP_HZ + 1) + 1;
   localparam int SAT_LIMIT   = (HZ_MAX / ROUND_HZ + 1) * ROUND_HZ;
   localparam int AF_NARROW_W = $clog2(SAT_LIMIT);
   localparam int F_W = ((IDX_W + STEP_W + 2) > (AF_NARROW_W + 1)) ?
                        (IDX_W + STEP_W + 2) : (AF_NARROW_W + 1);
   localparam int Q_W         = $clog2(SAT_LIMIT / ROUND_HZ);
   localparam int R_SH        = AF_NARROW_W + $clog2(ROUND_HZ + 1);
   localparam int R_M_W       = R_SH + 1;
   localparam logic [R_M_W-1:0] R_M =
      R_M_W'(((longint'(1) << R_SH) + ROUND_HZ - 1) / ROUND_HZ);

   localparam logic signed [WIN_W-1:0] CENTRE_W   = WIN_W'(CENTRE);
   localparam logic signed [K_W-1:0]   CENTRE_K   = K_W'(CENTRE);
   localparam logic signed [F_W-1:0]   STEP_F     = F_W'(BIN_STEP_HZ);
   localparam logic signed [F_W-1:0]   HALF_STEP  = F_W'(BIN_STEP_HZ / 2);
   localparam logic [F_W-1:0]          ROUND_HALF = F_W'(ROUND_HZ / 2);
   localparam logic signed [LVX_W-1:0] MARGIN_S   = LVX_W'(MARGIN_6DB);

   // ---------------------------------------------------------------------------
   // Configuration: passband edges are kept as bin indexes
   // ---------------------------------------------------------------------------
   logic                               csr_neg;
   logic [CSR_DATA_W-1:0]              csr_mag;
   logic [CSR_DATA_W+DIV_M_W-1:0]      csr_prod;
   logic [CSR_DATA_W-1:0]              csr_quo;
   logic signed [WIN_W-1:0]            csr_edge;
   logic signed [WIN_W-1:0]            win_start_ff;
   logic signed [WIN_W-1:0]            win_stop_ff;
   logic                               lsb_ff;

   always_comb begin
      csr_neg  = csr_wdata[CSR_DATA_W-1];
      csr_mag  = csr_neg ? (~csr_wdata + 1'b1) : csr_wdata;
      csr_prod = (CSR_DATA_W+DIV_M_W)'(csr_mag) * (CSR_DATA_W+DIV_M_W)'(DIV_M);
      csr_quo  = csr_prod[DIV_SH +: CSR_DATA_W];
      // Quotient truncates toward zero, so apply the sign after dividing
      csr_edge = csr_neg ? (CENTRE_W - WIN_W'(csr_quo)) : (CENTRE_W + WIN_W'(csr_quo));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_start_ff <= WIN_W'(START_RST);
         win_stop_ff  <= WIN_W'(STOP_RST);
         lsb_ff       <= 1'b0;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_PASSBAND_LOW:   win_start_ff <= csr_edge;
            CSR_PASSBAND_HIGH:  win_stop_ff  <= csr_edge;
            CSR_LOWER_SIDEBAND: lsb_ff       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Stage flow control: each stage advances when the one after it has room
   // ---------------------------------------------------------------------------
   logic in_v_ff, snap_v_ff, prod_v_ff, quo_v_ff, hval_v_ff, rsp_valid_ff;
   logic in_last_ff;
   logic out_free, hval_free, quo_free, prod_free, snap_free, acc_take;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign hval_free  = !hval_v_ff || out_free;
   assign quo_free   = !quo_v_ff || hval_free;
   assign prod_free  = !prod_v_ff || quo_free;
   assign snap_free  = !snap_v_ff || prod_free;
   // Plain bins always drain; a frame end needs room for its snapshot
   assign acc_take   = in_v_ff && (!in_last_ff || snap_free);
   assign req_tready = !in_v_ff || acc_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff      <= 1'b0;
         snap_v_ff    <= 1'b0;
         prod_v_ff    <= 1'b0;
         quo_v_ff     <= 1'b0;
         hval_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) in_v_ff      <= req_tvalid;
         if (snap_free)  snap_v_ff    <= acc_take && in_last_ff;
         if (prod_free)  prod_v_ff    <= snap_v_ff;
         if (quo_free)   quo_v_ff     <= prod_v_ff;
         if (hval_free)  hval_v_ff    <= quo_v_ff;
         if (out_free)   rsp_valid_ff <= hval_v_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Input register
   // ---------------------------------------------------------------------------
   logic signed [LEVEL_W-1:0] in_level_ff;

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_level_ff <= req_tdata[LEVEL_W-1:0];
         in_last_ff  <= req_tlast;
      end
   end

   // ---------------------------------------------------------------------------
   // Frame accumulator: window test, first strict maximum, level sum, bin count
   // ---------------------------------------------------------------------------
   logic [IDX_W-1:0]          bin_idx_ff;
   logic signed [LEVEL_W-1:0] peak_level_ff, peak_level_in;
   logic [IDX_W-1:0]          peak_idx_ff, peak_idx_in;
   logic signed [SUM_W-1:0]   level_sum_ff, level_sum_in;
   logic [IDX_W-1:0]          win_cnt_ff, win_cnt_in;
   logic signed [WIN_W-1:0]   idx_s;
   logic                      in_win, take_peak;

   always_comb begin
      idx_s     = WIN_W'({1'b0, bin_idx_ff});
      in_win    = (bin_idx_ff < IDX_W'(BIN_COUNT)) &&
                  (idx_s >= win_start_ff) && (idx_s < win_stop_ff);
      // The first bin inside the window always becomes the peak
      take_peak = in_win && ((win_cnt_ff == '0) || (in_level_ff > peak_level_ff));
      peak_level_in = take_peak ? in_level_ff : peak_level_ff;
      peak_idx_in   = take_peak ? bin_idx_ff : peak_idx_ff;
      level_sum_in  = in_win ? (level_sum_ff + SUM_W'(in_level_ff)) : level_sum_ff;
      win_cnt_in    = in_win ? (win_cnt_ff + 1'b1) : win_cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_idx_ff    <= '0;
         peak_level_ff <= LEVEL_MIN;
         peak_idx_ff   <= '0;
         level_sum_ff  <= '0;
         win_cnt_ff    <= '0;
      end else if (acc_take) begin
         if (in_last_ff) begin
            // Frame closed: start the next one afresh
            bin_idx_ff    <= '0;
            peak_level_ff <= LEVEL_MIN;
            peak_idx_ff   <= '0;
            level_sum_ff  <= '0;
            win_cnt_ff    <= '0;
         end else begin
            // Hold the index at BIN_COUNT on an overlong frame
            if (bin_idx_ff < IDX_W'(BIN_COUNT)) bin_idx_ff <= bin_idx_ff + 1'b1;
            peak_level_ff <= peak_level_in;
            peak_idx_ff   <= peak_idx_in;
            level_sum_ff  <= level_sum_in;
            win_cnt_ff    <= win_cnt_in;
         end
      end
   end

   // Frame snapshot, taken with the last bin included
   logic signed [LEVEL_W-1:0] snap_peak_ff;
   logic [IDX_W-1:0]          snap_idx_ff;
   logic signed [SUM_W-1:0]   snap_sum_ff;
   logic [IDX_W-1:0]          snap_cnt_ff;

   always_ff @(posedge clock) begin
      if (snap_free && acc_take && in_last_ff) begin
         snap_peak_ff <= peak_level_in;
         snap_idx_ff  <= peak_idx_in;
         snap_sum_ff  <= level_sum_in;
         snap_cnt_ff  <= win_cnt_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Multiply stage: (count-3)*(peak-6dB) against sum-3*peak, raw tone frequency
   // ---------------------------------------------------------------------------
   logic [IDX_W-1:0]          cnt_m3;
   logic signed [LVX_W-1:0]   peak_m;
   logic signed [CMP_W-1:0]   lhs_in, rhs_in, lhs_ff, rhs_ff;
   logic                      many_in, many_ff;
   logic signed [K_W-1:0]     k_in;
   logic signed [F_W-1:0]     f_in;
   logic [F_W-1:0]            af_in, af_ff;
   logic                      fneg_ff;
   logic [IDX_W-1:0]          prod_idx_ff;

   always_comb begin
      many_in = snap_cnt_ff > IDX_W'(3);
      cnt_m3  = snap_cnt_ff - IDX_W'(3);
      peak_m  = LVX_W'(snap_peak_ff) - MARGIN_S;
      lhs_in  = CMP_W'($signed({1'b0, cnt_m3})) * CMP_W'(peak_m);
      rhs_in  = CMP_W'(snap_sum_ff) - CMP_W'(snap_peak_ff) * CMP_W'(3);
      // Upper sideband reads the tone one bin lower
      k_in    = K_W'($signed({1'b0, snap_idx_ff})) - CENTRE_K -
                K_W'($signed({1'b0, ~lsb_ff}));
      f_in    = F_W'(k_in) * STEP_F + HALF_STEP;
      af_in   = (f_in[F_W-1] ? F_W'(-f_in) : F_W'(f_in)) + ROUND_HALF;
   end

   always_ff @(posedge clock) begin
      if (prod_free && snap_v_ff) begin
         lhs_ff      <= lhs_in;
         rhs_ff      <= rhs_in;
         many_ff     <= many_in;
         af_ff       <= af_in;
         fneg_ff     <= f_in[F_W-1];
         prod_idx_ff <= snap_idx_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Rounding stage: tone decision, divide by the rounding step, saturate
   // ---------------------------------------------------------------------------
   logic [AF_NARROW_W+R_M_W-1:0] q_prod;
   logic [Q_W-1:0]               q_in, q_ff;
   logic                         sat_in, sat_ff, tone_in, quo_tone_ff, quo_neg_ff;
   logic [IDX_W-1:0]             quo_idx_ff;

   always_comb begin
      tone_in = many_ff && (lhs_ff > rhs_ff);
      sat_in  = af_ff >= F_W'(SAT_LIMIT);
      q_prod  = (AF_NARROW_W+R_M_W)'(af_ff[AF_NARROW_W-1:0]) * (AF_NARROW_W+R_M_W)'(R_M);
      q_in    = q_prod[R_SH +: Q_W];
   end

   always_ff @(posedge clock) begin
      if (quo_free && prod_v_ff) begin
         quo_tone_ff <= tone_in;
         sat_ff      <= sat_in;
         q_ff        <= q_in;
         quo_neg_ff  <= fneg_ff;
         quo_idx_ff  <= prod_idx_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Frequency stage: history value, zero when there is no tone
   // ---------------------------------------------------------------------------
   logic [HZ_W-1:0]        mag_in;
   logic signed [HZ_W-1:0] hval_in, hval_ff;
   logic                   hval_tone_ff;
   logic [IDX_W-1:0]       hval_idx_ff;

   always_comb begin
      mag_in = sat_ff ? HZ_W'(HZ_MAX) : HZ_W'(q_ff * ROUND_HZ);
      if (!quo_tone_ff) hval_in = '0;
      else if (quo_neg_ff) hval_in = -$signed(mag_in);
      else hval_in = $signed(mag_in);
   end

   always_ff @(posedge clock) begin
      if (hval_free && quo_v_ff) begin
         hval_ff      <= hval_in;
         hval_tone_ff <= quo_tone_ff;
         hval_idx_ff  <= quo_idx_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // History and output register
   // ---------------------------------------------------------------------------
   logic signed [HZ_W-1:0] hist_ff [HISTORY_DEPTH];
   logic signed [HZ_W-1:0] hist_in [HISTORY_DEPTH];
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic                   agree_in;
   logic signed [HZ_W-1:0] notch_in;
   rsp_payload_type        rsp_data_ff;

   always_comb begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         hist_in[i] = (SLOT_W'(i) == slot_ff) ? hval_ff : hist_ff[i];
      end
      agree_in = 1'b1;
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
         if (hist_in[i] != hist_in[0]) agree_in = 1'b0;
      end
      slot_in = (slot_ff == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : (slot_ff + 1'b1);
      // Disagreement leaves the centre at zero; agreement on zero means no notch
      notch_in = '0;
      if (agree_in) begin
         notch_in = lsb_ff ? -hist_in[0] : hist_in[0];
         if (notch_in == '0) notch_in = EMPTY_NOTCH_HZ;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HISTORY_DEPTH; i++) hist_ff[i] <= '0;
         slot_ff <= '0;
      end else if (out_free && hval_v_ff) begin
         for (int i = 0; i < HISTORY_DEPTH; i++) hist_ff[i] <= hist_in[i];
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && hval_v_ff) begin
         rsp_data_ff.tone_found      <= hval_tone_ff;
         rsp_data_ff.history_agrees  <= agree_in;
         rsp_data_ff.notch_center_hz <= notch_in;
         rsp_data_ff.peak_bin        <= PEAK_BIN_W'(hval_idx_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- hdl/stnd_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the spectrum tone notch detector, bound to the top level.
`include "spectrum_tone_notch_detector_macros.svh"

module stnd_checker
   import stnd_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   rsp_payload_type rsp_view;

   assign rsp_view = rsp_tdata;

   // A stalled result holds
   `STND_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // No result straight out of reset
   `STND_ASSERT_NOW(a_reset_quiet, clock, reset, $past(reset), !rsp_tvalid, "result presented right after reset")

   // A split history yields a zero centre
   `STND_ASSERT_NOW(a_split_zero, clock, reset, rsp_tvalid && !rsp_view.history_agrees, rsp_view.notch_center_hz == '0, "notch centre set without agreement")

   // An agreed history never yields a zero centre
   `STND_ASSERT_NOW(a_agree_nonzero, clock, reset, rsp_tvalid && rsp_view.history_agrees, rsp_view.notch_center_hz != '0, "agreed notch centre is zero")

   // Agreement without a tone can only be the all-quiet history
   `STND_ASSERT_NOW(a_quiet_default, clock, reset, rsp_tvalid && rsp_view.history_agrees && !rsp_view.tone_found, rsp_view.notch_center_hz == EMPTY_NOTCH_HZ, "quiet history gave wrong centre")

endmodule

bind spectrum_tone_notch_detector stnd_checker u_stnd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- bench/tb_spectrum_tone_notch_detector.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the spectrum tone notch detector: random frames against a predictor.
module tb_spectrum_tone_notch_detector;
   import stnd_pkg::*;

   localparam int BINS        = BIN_COUNT_DEF;
   localparam int HIST        = HISTORY_DEPTH_DEF;
   localparam int BIN_STEP    = BIN_STEP_HZ_DEF;
   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_BINS = 600;

   typedef struct packed {
      logic signed [LEVEL_W-1:0] level;
      logic                      last;
   } spectrum_bin_type;

   // Clock, reset and every block input start at known values
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wen    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // Bins waiting for the driver, and frame reports waiting for the block
   spectrum_bin_type bins_to_send[$];
   rsp_payload_type  reports_due[$];
   spectrum_bin_type next_bin;
   rsp_payload_type  seen_report;
   rsp_payload_type  due_report;

   int idle_pct    = 0;
   int send_gap    = 0;
   int hold_gap    = 0;
   int mismatches  = 0;
   int cycle_count = 0;
   int win_start   = BINS / 2;
   int win_stop    = BINS / 2 + PASSBAND_HIGH_RST / BIN_STEP;

   // Predictor copy of the register file, reset values
   logic signed [HZ_W-1:0] band_low  = HZ_W'(PASSBAND_LOW_RST);
   logic signed [HZ_W-1:0] band_high = HZ_W'(PASSBAND_HIGH_RST);
   logic                   lsb_mode  = 1'b0;

   // Predictor copy of the frame accumulators and the tone history
   logic [PEAK_BIN_W-1:0]     bin_pos   = '0;
   logic signed [LEVEL_W-1:0] peak_lvl  = LEVEL_MIN;
   logic [PEAK_BIN_W-1:0]     peak_idx  = '0;
   logic signed [21:0]        lvl_sum   = '0;
   logic [7:0]                win_count = '0;
   logic signed [HZ_W-1:0]    tone_hist [HIST] = '{default: '0};
   int                        hist_slot = 0;

   spectrum_tone_notch_detector dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // Fold one accepted bin into the frame; on the frame end work out the report,
   // advance the history and queue the report.
   function automatic void absorb_bin(logic signed [LEVEL_W-1:0] level, logic last);
      int              start_bin;
      int              stop_bin;
      int              k;
      int              f;
      int              hz;
      int              notch;
      longint          lhs;
      longint          rhs;
      logic            tone;
      logic            agree;
      rsp_payload_type rep;
      start_bin = BINS / 2 + int'(band_low) / BIN_STEP;
      stop_bin  = BINS / 2 + int'(band_high) / BIN_STEP;
      // Only bins 0..BINS-1 can fall in the window; an inverted window holds none
      if (int'(bin_pos) < BINS && int'(bin_pos) >= start_bin && int'(bin_pos) < stop_bin) begin
         // the first window bin always takes the peak, later ones only when strictly higher
         if (win_count == 0 || level > peak_lvl) begin
            peak_lvl = level;
            peak_idx = bin_pos;
         end
         lvl_sum   = lvl_sum + level;
         win_count = win_count + 1'b1;
      end
      if (!last) begin
         // an overlong frame parks the index at BINS until its end
         if (int'(bin_pos) < BINS) bin_pos = bin_pos + 1'b1;
         return;
      end
      // Peak beats the mean of the others by 6 dB: no tone with three window bins or fewer
      tone = 1'b0;
      if (win_count > 3) begin
         lhs  = longint'(int'(win_count) - 3) * (longint'(peak_lvl) - MARGIN_6DB);
         rhs  = longint'(lvl_sum) - 3 * longint'(peak_lvl);
         tone = lhs > rhs;
      end
      hz = 0;
      if (tone) begin
         // upper sideband shifts the bin one down before the half-step offset
         k = int'(peak_idx) - BINS / 2 - (lsb_mode ? 0 : 1);
         f = k * BIN_STEP + BIN_STEP / 2;
         // round to the grid, halves away from zero, then saturate
         if (f >= 0) hz = ((f + ROUND_HZ / 2) / ROUND_HZ) * ROUND_HZ;
         else hz = -(((-f + ROUND_HZ / 2) / ROUND_HZ) * ROUND_HZ);
         if (hz > HZ_MAX) hz = HZ_MAX;
         if (hz < -HZ_MAX) hz = -HZ_MAX;
      end
      tone_hist[hist_slot] = HZ_W'(hz);
      hist_slot = (hist_slot + 1) % HIST;
      agree = 1'b1;
      for (int i = 1; i < HIST; i++)
         if (tone_hist[i] != tone_hist[0]) agree = 1'b0;
      // a disagreeing history leaves the notch at zero; an agreed zero becomes the default
      notch = 0;
      if (agree) begin
         notch = int'(tone_hist[0]);
         if (lsb_mode) notch = -notch;
         if (notch == 0) notch = int'(EMPTY_NOTCH_HZ);
      end
      rep.tone_found      = tone;
      rep.history_agrees  = agree;
      rep.notch_center_hz = HZ_W'(notch);
      rep.peak_bin        = peak_idx;
      reports_due.push_back(rep);
      bin_pos   = '0;
      peak_lvl  = LEVEL_MIN;
      peak_idx  = '0;
      lvl_sum   = '0;
      win_count = '0;
   endfunction

   // Driver: present queued bins, predict each one as its transaction completes, and
   // drop valid for bursts of idle cycles, mid-frame included.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready)
            absorb_bin(req_tdata[LEVEL_W-1:0], req_tlast);
         // hold the current bin until it is taken
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (bins_to_send.size() != 0 && $urandom_range(0, 99) < idle_pct) begin
               send_gap = $urandom_range(0, 5);
               req_tvalid <= 1'b0;
            end else if (bins_to_send.size() != 0) begin
               next_bin = bins_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {{(REQ_TDATA_W - LEVEL_W){1'b0}}, next_bin.level};
               req_tlast  <= next_bin.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare every completed report with the oldest prediction, and
   // stall the report channel in bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen_report = rsp_tdata;
            if (reports_due.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected report: tone %0b agree %0b notch %0d bin %0d",
                           seen_report.tone_found, seen_report.history_agrees,
                           seen_report.notch_center_hz, seen_report.peak_bin);
               mismatches++;
            end else begin
               due_report = reports_due.pop_front();
               if (seen_report.tone_found !== due_report.tone_found ||
                   seen_report.history_agrees !== due_report.history_agrees ||
                   seen_report.notch_center_hz !== due_report.notch_center_hz ||
                   seen_report.peak_bin !== due_report.peak_bin) begin
                  if (mismatches < 10) begin
                     $write("report mismatch: expected tone %0b agree %0b notch %0d bin %0d,",
                            due_report.tone_found, due_report.history_agrees,
                            due_report.notch_center_hz, due_report.peak_bin);
                     $display(" got tone %0b agree %0b notch %0d bin %0d",
                              seen_report.tone_found, seen_report.history_agrees,
                              seen_report.notch_center_hz, seen_report.peak_bin);
                  end
                  mismatches++;
               end
            end
         end
         if (hold_gap > 0) begin
            hold_gap--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 99) < idle_pct) begin
            hold_gap = $urandom_range(0, 5);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: a stuck handshake ends the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic push_bin(int lvl, bit last);
      spectrum_bin_type b;
      if (lvl > 8191) lvl = 8191;
      if (lvl < -8192) lvl = -8192;
      b.level = LEVEL_W'(lvl);
      b.last  = last;
      bins_to_send.push_back(b);
   endtask

   // Queue one frame: noise around a base level, an optional raised bin, and now
   // and then a full-range outlier.
   task automatic queue_frame(int len, int tone_at, int base_lvl, int spread, int boost);
      int lvl;
      for (int i = 0; i < len; i++) begin
         lvl = base_lvl;
         if (spread > 0) lvl = base_lvl + int'($urandom_range(0, 2 * spread)) - spread;
         if (i == tone_at) lvl = base_lvl + spread + boost;
         if ($urandom_range(0, 15) == 0) lvl = int'($urandom_range(0, 16383)) - 8192;
         push_bin(lvl, i == len - 1);
      end
   endtask

   task automatic write_csr(csr_index_type idx, int value);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      case (idx)
         CSR_PASSBAND_LOW:   band_low  = HZ_W'(value);
         CSR_PASSBAND_HIGH:  band_high = HZ_W'(value);
         CSR_LOWER_SIDEBAND: lsb_mode  = value[0];
         default: ;
      endcase
   endtask

   // Write all three registers back to back, then release the write enable
   task automatic configure(int lo, int hi, bit lsb);
      write_csr(CSR_PASSBAND_LOW, lo);
      write_csr(CSR_PASSBAND_HIGH, hi);
      write_csr(CSR_LOWER_SIDEBAND, int'(lsb));
      @(posedge clock);
      csr_wen <= 1'b0;
      win_start = BINS / 2 + lo / BIN_STEP;
      win_stop  = BINS / 2 + hi / BIN_STEP;
   endtask

   // Wait for every bin to go and every report to come back, then let the pipeline settle
   task automatic drain();
      while (bins_to_send.size() != 0 || req_tvalid || reports_due.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   initial begin
      int  lo;
      int  hi;
      int  len;
      int  tone_at;
      int  random_sent;
      bit  agree_run;
      random_sent = 0;
      idle_pct    = 20;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: a lone bin at index 0 falls outside the 0..3000 Hz window
      push_bin(0, 1'b1);
      drain();

      // Window of bins 0..4, lower sideband
      configure(-6250, -6000, 1'b1);
      // strong tone between rails at the bottom of the level range
      push_bin(-8192, 1'b0); push_bin(-8192, 1'b0); push_bin(8191, 1'b0);
      push_bin(-8192, 1'b0); push_bin(-8192, 1'b0); push_bin(-8192, 1'b1);
      // flat frame: the first of equal bins keeps the peak, no tone
      repeat (4) push_bin(7, 1'b0);
      push_bin(7, 1'b1);
      // three window bins only: no tone however high the peak
      push_bin(8191, 1'b0); push_bin(-8192, 1'b0); push_bin(-8192, 1'b1);
      // walk the level bits through zeros, ones and both alternating patterns
      push_bin(0, 1'b0); push_bin(-1, 1'b0); push_bin(5461, 1'b0);
      push_bin(-5462, 1'b0); push_bin(0, 1'b1);
      drain();

      // Whole spectrum, upper sideband: top bin, an overlong frame, a near-flat frame
      configure(-6250, 6250, 1'b0);
      queue_frame(BINS, BINS - 1, -3000, 200, 2000);
      queue_frame(BINS + 25, 200, 0, 50, 800);
      queue_frame(BINS, 0, 1000, 0, 1);
      drain();

      // Back to the reset window: three frames with one tone so the history agrees
      configure(PASSBAND_LOW_RST, PASSBAND_HIGH_RST, 1'b0);
      tone_at = $urandom_range(BINS / 2, win_stop - 1);
      repeat (3) queue_frame(BINS, tone_at, -2000, 100, 1200);
      drain();

      // Window past the last bin: always empty
      idle_pct = 40;
      configure(6250, 6250, 1'b1);
      repeat (3) queue_frame($urandom_range(1, 20), 0, 0, 300, 900);
      drain();

      // Inverted window near the start of the frame
      configure(-5000, -5500, 1'b0);
      repeat (3) queue_frame(30, 20, -500, 100, 1500);
      drain();

      // Random settings with the window near bin 0, so that short frames reach it.
      // Mostly runs of three frames with one tone position; the rest scatter the tone
      // or cut the frame short. Drop idling for the last stretch.
      while (random_sent < RANDOM_BINS) begin
         lo = -6250 + int'($urandom_range(0, 1500));
         hi = lo + int'($urandom_range(0, 2000));
         configure(lo, hi, 1'(($urandom_range(0, 1))));
         case ($urandom_range(0, 2))
            0:       idle_pct = 0;
            1:       idle_pct = 15;
            default: idle_pct = 40;
         endcase
         if (random_sent > RANDOM_BINS - 400) idle_pct = 0;
         repeat ($urandom_range(2, 5)) begin
            agree_run = $urandom_range(0, 9) < 7;
            tone_at = (win_stop > win_start) ? $urandom_range(win_start, win_stop - 1) : 0;
            repeat (3) begin
               if (!agree_run && win_stop > win_start)
                  tone_at = $urandom_range(win_start, win_stop - 1);
               if ($urandom_range(0, 9) == 0) len = $urandom_range(1, win_start + 3);
               else len = win_stop + int'($urandom_range(0, 6));
               if (len < 1) len = 1;
               queue_frame(len, tone_at, int'($urandom_range(0, 16383)) - 8192,
                           ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 400)),
                           $urandom_range(0, 1500));
               random_sent += len;
            end
         end
         drain();
      end

      mismatches += reports_due.size();
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/stnd_pkg.sv
hdl/spectrum_tone_notch_detector.sv
hdl/stnd_checker.sv
bench/tb_spectrum_tone_notch_detector.sv
